### rtl/ahdp_pkg.sv
// Shared types and constants for the array header dictionary parser.
// Holds the parse state record, the result record and the status codes.
// Used by ahdp_core and array_header_dict_parser_top.
`timescale 1ns / 1ps

package ahdp_pkg;

    localparam int MAX_DIMS  = 4;
    localparam int DIM_BITS  = 32;
    localparam int CNT_W     = $clog2(MAX_DIMS + 1);
    localparam int IDX_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int OUT_DIMS  = 4;
    localparam int OUT_BITS  = 32;
    localparam int NUM_KEYS  = 3;
    localparam int NUM_TYPES = 6;

    typedef enum logic [3:0] {
        PH_OPEN,
        PH_DICT,
        PH_KEYSTART,
        PH_KEY,
        PH_COLON,
        PH_VALUE,
        PH_DSTR,
        PH_BOOL_T,
        PH_BOOL_F,
        PH_TUP,
        PH_SKIPSTR,
        PH_SKIPTUP,
        PH_SKIPRAW,
        PH_AFTER,
        PH_DONE,
        PH_ERR
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NO_BRACE,
        ST_NO_COLON,
        ST_BAD_DESCR,
        ST_BAD_TUPLE,
        ST_OVERFLOW,
        ST_BAD_BOOL
    } status_t;

    typedef enum logic [2:0] {
        ET_NONE,
        ET_U1,
        ET_I2,
        ET_I4,
        ET_I8,
        ET_F4,
        ET_F8
    } elem_t;

    typedef struct packed {
        phase_t                             phase;
        logic [NUM_KEYS-1:0]                key_match;
        logic [3:0]                         match_pos;
        logic                               esc;
        logic [NUM_TYPES-1:0]               descr_match;
        logic [DIM_BITS-1:0]                acc;
        logic                               seen;
        logic [MAX_DIMS-1:0][DIM_BITS-1:0]  dims;
        logic [CNT_W-1:0]                   found;
        elem_t                              type_seen;
        status_t                            err;
    } state_t;

    typedef struct packed {
        status_t                            status;
        elem_t                              elem;
        logic [2:0]                         count;
        logic [OUT_DIMS-1:0][OUT_BITS-1:0]  dims;
    } result_t;

    function automatic state_t state_reset();
        state_t s;
        s.phase       = PH_OPEN;
        s.key_match   = '1;
        s.match_pos   = '0;
        s.esc         = 1'b0;
        s.descr_match = '1;
        s.acc         = '0;
        s.seen        = 1'b0;
        s.dims        = '0;
        s.found       = '0;
        s.type_seen   = ET_NONE;
        s.err         = ST_OK;
        return s;
    endfunction

endpackage

### rtl/array_header_dict_parser_top.sv
// Array header dictionary parser: input register, parse step, result register.
// Parses descr, fortran_order and shape out of a stream of header bytes.
// Depends on ahdp_pkg and ahdp_core.
//
// Usage:
//   Input channel text_valid / text_stall carries one header byte per item
//   (text_char) with final_char set on the last byte of a header.
//   Result channel result_valid / result_stall carries one item per header:
//   status, elem_type, dim_count and dim_zero .. dim_three.
//   Throughput: one byte per cycle while text_stall is low, set by the
//   combinational parse step between the input register and the state
//   and result registers. A final byte passes from the input register to
//   the result register when it fires; non-final bytes give no result.
//   A stalled result holds; the next header's bytes keep flowing until a
//   further final byte reaches the input register, which then holds and
//   raises text_stall until the waiting result is taken.
//   Reset clears the input and result valids and puts the parser back at the
//   start of a header; after each final byte the parser restarts as well.
`timescale 1ns / 1ps

module array_header_dict_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_stall,
    input  logic [7:0]  text_char,
    input  logic        final_char,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [2:0]  elem_type,
    output logic [2:0]  dim_count,
    output logic [31:0] dim_zero,
    output logic [31:0] dim_one,
    output logic [31:0] dim_two,
    output logic [31:0] dim_three
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        char_reg;
    logic              final_reg;
    ahdp_pkg::state_t  st_reg;
    ahdp_pkg::state_t  st_next;
    logic              result_valid_reg;
    logic              result_valid_next;
    ahdp_pkg::result_t result_reg;
    ahdp_pkg::state_t  core_nxt;
    ahdp_pkg::result_t core_res;
    logic              fire;
    logic              accept;

    ahdp_core u_core (
        .cur       (st_reg),
        .text_char (char_reg),
        .nxt       (core_nxt),
        .res       (core_res)
    );

    assign fire       = in_valid_reg && (!final_reg || !result_valid_reg || !result_stall);
    assign text_stall = in_valid_reg && !fire;
    assign accept     = text_valid && !text_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept) in_valid_next = 1'b1;
        else if (fire) in_valid_next = 1'b0;

        st_next = st_reg;
        if (fire) begin
            st_next = final_reg ? ahdp_pkg::state_reset() : core_nxt;
        end

        result_valid_next = result_valid_reg;
        if (fire && final_reg) result_valid_next = 1'b1;
        else if (!result_stall) result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            st_reg           <= ahdp_pkg::state_reset();
        end
        else begin
            in_valid_reg     <= in_valid_next;
            result_valid_reg <= result_valid_next;
            st_reg           <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            char_reg  <= text_char;
            final_reg <= final_char;
        end
        if (fire && final_reg) begin
            result_reg <= core_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = result_reg.status;
    assign elem_type    = result_reg.elem;
    assign dim_count    = result_reg.count;
    assign dim_zero     = result_reg.dims[0];
    assign dim_one      = result_reg.dims[1];
    assign dim_two      = result_reg.dims[2];
    assign dim_three    = result_reg.dims[3];

`ifndef SYNTHESIS
    a_stall_only_on_blocked_final: assert property (
        @(posedge clk) disable iff (!rst_n)
        text_stall |-> (in_valid_reg && final_reg && result_valid_reg && result_stall)
    ) else $error("input stalled without a blocked final item");

    a_result_from_final: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !$past(result_valid_reg)) |-> $past(in_valid_reg && final_reg)
    ) else $error("result appeared without a final item");

    a_error_fields_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.status != ahdp_pkg::ST_OK) |->
            (result_reg.elem == ahdp_pkg::ET_NONE && result_reg.count == 3'd0 &&
             result_reg.dims == '0)
    ) else $error("error result carries nonzero fields");

    a_restart_after_final: assert property (
        @(posedge clk) disable iff (!rst_n)
        (fire && final_reg) |=>
            (st_reg.phase == ahdp_pkg::PH_OPEN && st_reg.err == ahdp_pkg::ST_OK)
    ) else $error("parser did not restart after a final item");

    a_error_phase_consistent: assert property (
        @(posedge clk) disable iff (!rst_n)
        (st_reg.err != ahdp_pkg::ST_OK) == (st_reg.phase == ahdp_pkg::PH_ERR)
    ) else $error("error code and error phase disagree");
`endif

endmodule

### rtl/ahdp_core.sv
// Combinational parse step: one header byte against the current parse state.
// Gives the next state and the result record that the byte would end with.
// Depends on ahdp_pkg.
`timescale 1ns / 1ps

module ahdp_core (
    input  ahdp_pkg::state_t  cur,
    input  logic [7:0]        text_char,
    output ahdp_pkg::state_t  nxt,
    output ahdp_pkg::result_t res
);

    localparam int MAX_HOPS = 8;
    localparam int PW       = ahdp_pkg::DIM_BITS + 4;
    localparam int MIN_DIMS = (ahdp_pkg::MAX_DIMS < ahdp_pkg::OUT_DIMS) ?
                              ahdp_pkg::MAX_DIMS : ahdp_pkg::OUT_DIMS;
    localparam int KEY_DESCR   = 0;
    localparam int KEY_FORTRAN = 1;
    localparam int KEY_SHAPE   = 2;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UPPER_T = 8'h54;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [103:0] KEY_TXT [ahdp_pkg::NUM_KEYS] =
        '{"descr", "fortran_order", "shape"};
    localparam logic [3:0] KEY_LEN [ahdp_pkg::NUM_KEYS] = '{4'd5, 4'd13, 4'd5};
    localparam logic [23:0] TYPE_TXT [ahdp_pkg::NUM_TYPES] =
        '{"|u1", "<i2", "<i4", "<i8", "<f4", "<f8"};
    localparam logic [31:0] TRUE_TXT  = "True";
    localparam logic [39:0] FALSE_TXT = "False";

    function automatic logic [3:0] bump(input logic [3:0] pos);
        return (pos < 4'd15) ? pos + 4'd1 : pos;
    endfunction

    function automatic logic [ahdp_pkg::NUM_KEYS-1:0] key_feed(
        input logic [ahdp_pkg::NUM_KEYS-1:0] km,
        input logic [3:0]                    pos,
        input logic [7:0]                    c
    );
        logic [ahdp_pkg::NUM_KEYS-1:0] r;
        int idx;
        r = km;
        for (int k = 0; k < ahdp_pkg::NUM_KEYS; k++) begin
            idx = int'(KEY_LEN[k]) - 1 - int'(pos);
            if (idx < 0) begin
                r[k] = 1'b0;
            end
            else if (KEY_TXT[k][8*idx +: 8] != c) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [ahdp_pkg::NUM_KEYS-1:0] key_close(
        input logic [ahdp_pkg::NUM_KEYS-1:0] km,
        input logic [3:0]                    pos
    );
        logic [ahdp_pkg::NUM_KEYS-1:0] r;
        r = '0;
        for (int k = 0; k < ahdp_pkg::NUM_KEYS; k++) begin
            if (km[k] && pos == KEY_LEN[k]) begin
                r = ahdp_pkg::NUM_KEYS'(1 << k);
            end
        end
        return r;
    endfunction

    function automatic logic [ahdp_pkg::NUM_TYPES-1:0] descr_feed(
        input logic [ahdp_pkg::NUM_TYPES-1:0] dm,
        input logic [3:0]                     pos,
        input logic [7:0]                     c
    );
        logic [ahdp_pkg::NUM_TYPES-1:0] r;
        int idx;
        r = dm;
        idx = 2 - int'(pos);
        for (int k = 0; k < ahdp_pkg::NUM_TYPES; k++) begin
            if (idx < 0) begin
                r[k] = 1'b0;
            end
            else if (TYPE_TXT[k][8*idx +: 8] != c) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic ahdp_pkg::elem_t first_type(
        input logic [ahdp_pkg::NUM_TYPES-1:0] dm
    );
        ahdp_pkg::elem_t t;
        t = ahdp_pkg::ET_NONE;
        for (int k = ahdp_pkg::NUM_TYPES - 1; k >= 0; k--) begin
            if (dm[k]) begin
                t = ahdp_pkg::elem_t'(3'(k + 1));
            end
        end
        return t;
    endfunction

    function automatic ahdp_pkg::state_t fail(
        input ahdp_pkg::state_t  s,
        input ahdp_pkg::status_t code
    );
        ahdp_pkg::state_t r;
        r = s;
        if (r.err == ahdp_pkg::ST_OK) begin
            r.err = code;
        end
        r.phase = ahdp_pkg::PH_ERR;
        return r;
    endfunction

    logic                           is_blank;
    logic                           is_digit;
    logic [3:0]                     digit;
    logic [PW-1:0]                  acc_prod;
    logic                           acc_over;
    logic                           bool_ok;
    int                             bool_idx;
    ahdp_pkg::phase_t               ph;
    logic [ahdp_pkg::NUM_KEYS-1:0]  km;
    logic                           clr;
    logic                           hop_done;
    ahdp_pkg::state_t               s;
    ahdp_pkg::state_t               n;

    ahdp_pkg::status_t              ferr;
    ahdp_pkg::elem_t                ftype;
    logic [ahdp_pkg::CNT_W-1:0]     ffound;
    logic [ahdp_pkg::MAX_DIMS-1:0][ahdp_pkg::DIM_BITS-1:0] fdims;
    logic [ahdp_pkg::NUM_TYPES-1:0] fdm;
    logic [3:0]                     fpos;

    assign is_blank = (text_char == CH_SPACE) || (text_char == CH_TAB) ||
                      (text_char == CH_LF) || (text_char == CH_CR);
    assign is_digit = (text_char >= CH_ZERO) && (text_char <= CH_NINE);
    assign digit    = 4'(text_char - CH_ZERO);
    assign acc_prod = (PW'(cur.acc) << 3) + (PW'(cur.acc) << 1) + PW'(digit);
    assign acc_over = |acc_prod[PW-1:ahdp_pkg::DIM_BITS];

    // next state: follow the phases that pass the byte on, then consume it
    always_comb
    begin
        ph       = cur.phase;
        km       = cur.key_match;
        clr      = 1'b0;
        hop_done = 1'b0;
        for (int i = 0; i < MAX_HOPS; i++) begin
            if (!hop_done) begin
                unique case (ph)
                    ahdp_pkg::PH_DICT:
                    begin
                        if (is_blank || text_char == CH_RBRACE) hop_done = 1'b1;
                        else ph = ahdp_pkg::PH_KEYSTART;
                    end
                    ahdp_pkg::PH_KEYSTART:
                    begin
                        if (text_char == CH_QUOTE) begin
                            hop_done = 1'b1;
                        end
                        else begin
                            km = '0;
                            ph = ahdp_pkg::PH_COLON;
                        end
                    end
                    ahdp_pkg::PH_VALUE:
                    begin
                        if (is_blank || km[KEY_DESCR] || km[KEY_FORTRAN]) begin
                            hop_done = 1'b1;
                        end
                        else if (km[KEY_SHAPE]) begin
                            if (text_char == CH_LPAREN) begin
                                hop_done = 1'b1;
                            end
                            else begin
                                clr = 1'b1;
                                ph  = ahdp_pkg::PH_AFTER;
                            end
                        end
                        else if (text_char == CH_QUOTE || text_char == CH_LPAREN) begin
                            hop_done = 1'b1;
                        end
                        else begin
                            ph = ahdp_pkg::PH_SKIPRAW;
                        end
                    end
                    ahdp_pkg::PH_SKIPRAW:
                    begin
                        if (text_char == CH_COMMA || text_char == CH_RBRACE) begin
                            ph = ahdp_pkg::PH_AFTER;
                        end
                        else begin
                            hop_done = 1'b1;
                        end
                    end
                    ahdp_pkg::PH_AFTER:
                    begin
                        if (is_blank || text_char == CH_COMMA) hop_done = 1'b1;
                        else ph = ahdp_pkg::PH_DICT;
                    end
                    default: hop_done = 1'b1;
                endcase
            end
        end

        s           = cur;
        s.phase     = ph;
        s.key_match = km;
        if (clr) begin
            s.dims  = '0;
            s.found = '0;
            s.acc   = '0;
            s.seen  = 1'b0;
        end

        bool_ok  = 1'b0;
        bool_idx = 0;
        n        = s;
        unique case (ph)
            ahdp_pkg::PH_OPEN:
            begin
                if (text_char == CH_LBRACE) n.phase = ahdp_pkg::PH_DICT;
                else if (!is_blank) n = fail(s, ahdp_pkg::ST_NO_BRACE);
            end
            ahdp_pkg::PH_DICT:
            begin
                if (text_char == CH_RBRACE) n.phase = ahdp_pkg::PH_DONE;
            end
            ahdp_pkg::PH_KEYSTART:
            begin
                n.key_match = '1;
                n.match_pos = '0;
                n.esc       = 1'b0;
                n.phase     = ahdp_pkg::PH_KEY;
            end
            ahdp_pkg::PH_KEY:
            begin
                if (s.esc) begin
                    n.esc       = 1'b0;
                    n.key_match = key_feed(s.key_match, s.match_pos, text_char);
                    n.match_pos = bump(s.match_pos);
                end
                else if (text_char == CH_BSLASH) begin
                    n.esc = 1'b1;
                end
                else if (text_char == CH_QUOTE) begin
                    n.key_match = key_close(s.key_match, s.match_pos);
                    n.phase     = ahdp_pkg::PH_COLON;
                end
                else begin
                    n.key_match = key_feed(s.key_match, s.match_pos, text_char);
                    n.match_pos = bump(s.match_pos);
                end
            end
            ahdp_pkg::PH_COLON:
            begin
                if (text_char == CH_COLON) n.phase = ahdp_pkg::PH_VALUE;
                else if (!is_blank) n = fail(s, ahdp_pkg::ST_NO_COLON);
            end
            ahdp_pkg::PH_VALUE:
            begin
                if (is_blank) begin
                    n = s;
                end
                else if (s.key_match[KEY_DESCR]) begin
                    if (text_char == CH_QUOTE) begin
                        n.descr_match = '1;
                        n.match_pos   = '0;
                        n.esc         = 1'b0;
                        n.phase       = ahdp_pkg::PH_DSTR;
                    end
                    else begin
                        n = fail(s, ahdp_pkg::ST_BAD_DESCR);
                    end
                end
                else if (s.key_match[KEY_FORTRAN]) begin
                    n.match_pos = 4'd1;
                    if (text_char == CH_UPPER_T) n.phase = ahdp_pkg::PH_BOOL_T;
                    else if (text_char == CH_UPPER_F) n.phase = ahdp_pkg::PH_BOOL_F;
                    else n = fail(n, ahdp_pkg::ST_BAD_BOOL);
                end
                else if (s.key_match[KEY_SHAPE]) begin
                    n.dims  = '0;
                    n.found = '0;
                    n.acc   = '0;
                    n.seen  = 1'b0;
                    n.phase = ahdp_pkg::PH_TUP;
                end
                else if (text_char == CH_QUOTE) begin
                    n.esc   = 1'b0;
                    n.phase = ahdp_pkg::PH_SKIPSTR;
                end
                else begin
                    n.phase = ahdp_pkg::PH_SKIPTUP;
                end
            end
            ahdp_pkg::PH_DSTR:
            begin
                if (s.esc) begin
                    n.esc         = 1'b0;
                    n.descr_match = descr_feed(s.descr_match, s.match_pos, text_char);
                    n.match_pos   = bump(s.match_pos);
                end
                else if (text_char == CH_BSLASH) begin
                    n.esc = 1'b1;
                end
                else if (text_char == CH_QUOTE) begin
                    if (s.match_pos == 4'd3 && |s.descr_match) begin
                        n.type_seen = first_type(s.descr_match);
                        n.phase     = ahdp_pkg::PH_AFTER;
                    end
                    else begin
                        n = fail(s, ahdp_pkg::ST_BAD_DESCR);
                    end
                end
                else begin
                    n.descr_match = descr_feed(s.descr_match, s.match_pos, text_char);
                    n.match_pos   = bump(s.match_pos);
                end
            end
            ahdp_pkg::PH_BOOL_T:
            begin
                bool_idx = 3 - int'(s.match_pos);
                bool_ok  = (bool_idx >= 0) && (TRUE_TXT[8*bool_idx +: 8] == text_char);
                if (bool_ok) begin
                    n.match_pos = s.match_pos + 4'd1;
                    if (s.match_pos == 4'd3) n.phase = ahdp_pkg::PH_AFTER;
                end
                else begin
                    n = fail(s, ahdp_pkg::ST_BAD_BOOL);
                end
            end
            ahdp_pkg::PH_BOOL_F:
            begin
                bool_idx = 4 - int'(s.match_pos);
                bool_ok  = (bool_idx >= 0) && (FALSE_TXT[8*bool_idx +: 8] == text_char);
                if (bool_ok) begin
                    n.match_pos = s.match_pos + 4'd1;
                    if (s.match_pos == 4'd4) n.phase = ahdp_pkg::PH_AFTER;
                end
                else begin
                    n = fail(s, ahdp_pkg::ST_BAD_BOOL);
                end
            end
            ahdp_pkg::PH_TUP:
            begin
                if (is_digit) begin
                    if (acc_over) begin
                        n = fail(s, ahdp_pkg::ST_OVERFLOW);
                    end
                    else begin
                        n.acc  = acc_prod[ahdp_pkg::DIM_BITS-1:0];
                        n.seen = 1'b1;
                    end
                end
                else if (is_blank || text_char == CH_COMMA || text_char == CH_RPAREN) begin
                    if (s.seen && s.found >= ahdp_pkg::CNT_W'(ahdp_pkg::MAX_DIMS)) begin
                        n = fail(s, ahdp_pkg::ST_OVERFLOW);
                    end
                    else begin
                        if (s.seen) begin
                            n.dims[s.found[ahdp_pkg::IDX_W-1:0]] = s.acc;
                            n.found = s.found + 1'b1;
                            n.acc   = '0;
                            n.seen  = 1'b0;
                        end
                        if (text_char == CH_RPAREN) n.phase = ahdp_pkg::PH_AFTER;
                    end
                end
                else begin
                    n = fail(s, ahdp_pkg::ST_BAD_TUPLE);
                end
            end
            ahdp_pkg::PH_SKIPSTR:
            begin
                if (s.esc) n.esc = 1'b0;
                else if (text_char == CH_BSLASH) n.esc = 1'b1;
                else if (text_char == CH_QUOTE) n.phase = ahdp_pkg::PH_AFTER;
            end
            ahdp_pkg::PH_SKIPTUP:
            begin
                if (text_char == CH_RPAREN) begin
                    n.phase = ahdp_pkg::PH_AFTER;
                end
                else if (!(is_digit || is_blank || text_char == CH_COMMA)) begin
                    n = fail(s, ahdp_pkg::ST_BAD_TUPLE);
                end
            end
            ahdp_pkg::PH_AFTER:
            begin
                if (text_char == CH_COMMA) n.phase = ahdp_pkg::PH_DICT;
            end
            default: n = s;
        endcase
        nxt = n;
    end

    // result: close whatever the header leaves open at its last byte
    always_comb
    begin
        ferr   = nxt.err;
        ftype  = nxt.type_seen;
        ffound = nxt.found;
        fdims  = nxt.dims;
        fdm    = nxt.descr_match;
        fpos   = nxt.match_pos;
        unique case (nxt.phase) inside
            ahdp_pkg::PH_OPEN: ferr = ahdp_pkg::ST_NO_BRACE;
            ahdp_pkg::PH_KEY, ahdp_pkg::PH_COLON: ferr = ahdp_pkg::ST_NO_COLON;
            ahdp_pkg::PH_VALUE:
            begin
                if (nxt.key_match[KEY_DESCR]) begin
                    ferr = ahdp_pkg::ST_BAD_DESCR;
                end
                else if (nxt.key_match[KEY_FORTRAN]) begin
                    ferr = ahdp_pkg::ST_BAD_BOOL;
                end
                else if (nxt.key_match[KEY_SHAPE]) begin
                    ffound = '0;
                    fdims  = '0;
                end
            end
            ahdp_pkg::PH_DSTR:
            begin
                if (nxt.esc) begin
                    fdm  = descr_feed(nxt.descr_match, nxt.match_pos, CH_BSLASH);
                    fpos = bump(nxt.match_pos);
                end
                if (fpos == 4'd3 && |fdm) ftype = first_type(fdm);
                else ferr = ahdp_pkg::ST_BAD_DESCR;
            end
            ahdp_pkg::PH_BOOL_T, ahdp_pkg::PH_BOOL_F: ferr = ahdp_pkg::ST_BAD_BOOL;
            ahdp_pkg::PH_TUP:
            begin
                if (nxt.seen) begin
                    if (nxt.found >= ahdp_pkg::CNT_W'(ahdp_pkg::MAX_DIMS)) begin
                        ferr = ahdp_pkg::ST_OVERFLOW;
                    end
                    else begin
                        fdims[nxt.found[ahdp_pkg::IDX_W-1:0]] = nxt.acc;
                        ffound = nxt.found + 1'b1;
                    end
                end
            end
            default: ferr = nxt.err;
        endcase

        res.status = ferr;
        res.elem   = ahdp_pkg::ET_NONE;
        res.count  = '0;
        res.dims   = '0;
        if (ferr == ahdp_pkg::ST_OK) begin
            res.elem  = ftype;
            res.count = 3'(ffound);
            for (int k = 0; k < MIN_DIMS; k++) begin
                res.dims[k] = ahdp_pkg::OUT_BITS'(fdims[k]);
            end
        end
    end

endmodule
